// ===== hdl/mrct_pkg.sv =====
package mrct_pkg;

    // action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // register select codes
    localparam logic [1:0] REG_INTERVAL = 2'd0;
    localparam logic [1:0] REG_CONTROL  = 2'd1;
    localparam logic [1:0] REG_TIMER    = 2'd2;
    localparam logic [1:0] REG_STATUS   = 2'd3;

    // timer mode codes (anything other than repeat behaves as one-shot)
    localparam logic [1:0] MODE_REPEAT = 2'd0;

    localparam int          COUNT_W        = 24;
    localparam int          FORCE_LOAD_BIT = 31;
    localparam logic [23:0] IDLE_COUNT     = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  channel;
        logic [1:0]  reg_select;
        logic [31:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic [1:0]  irq_channel;
    } out_item_t;

endpackage

// ===== hdl/multi_rate_countdown_timer.sv =====
// multi-rate countdown timer, CHANNELS down-counters of 24 bits behind a register port
//
// s_ channel: one item per cycle while s_ready is high, each a tick, a register write or a register read.
//   a tick counts down every running channel; writes and reads address one
//   channel's interval, control, timer or status register.
// m_ channel: one result item for every input item, in order, carrying the read
//   data (zero for ticks and writes) and the interrupt state after the item.
// path: an accepted item lands in the input register; the result register is then
//   written from the single-pass update of the channel state once it is empty or
//   its result is taken.
// throughput: one item per cycle unless the result stalls; the input register and the result register
//   each hold one item, so an item is taken while a finished result waits.
// stall: when m_ready stays low the result register holds, the input register
//   fills, and s_ready drops until the result is taken.
// reset: aresetn low for one clock clears all channels to idle (timer reads
//   0xFFFFFF, reload 0, repeat mode, interrupts disabled, flags clear) and
//   empties both registers.
module multi_rate_countdown_timer
    import mrct_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    // pipeline registers
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      advance;

    // channel state
    logic [COUNT_W-1:0] reload_reg [CHANNELS];
    logic [COUNT_W-1:0] reload_next [CHANNELS];
    logic [COUNT_W-1:0] count_reg [CHANNELS];
    logic [COUNT_W-1:0] count_next [CHANNELS];
    logic [CHANNELS-1:0] running_reg, running_next;
    logic [CHANNELS-1:0] int_en_reg, int_en_next;
    logic [CHANNELS-1:0] flag_reg, flag_next;
    logic [1:0]          mode_reg [CHANNELS];
    logic [1:0]          mode_next [CHANNELS];

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // single-pass update of every channel and the result
    always_comb begin
        logic               is_tick;
        logic               hit;
        logic [COUNT_W-1:0] load_v;
        logic [COUNT_W-1:0] wr_v;
        is_tick = (in_item_reg.action == ACT_TICK);
        wr_v    = in_item_reg.write_data[COUNT_W-1:0];
        out_item_next = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            reload_next[c]  = reload_reg[c];
            count_next[c]   = count_reg[c];
            running_next[c] = running_reg[c];
            int_en_next[c]  = int_en_reg[c];
            mode_next[c]    = mode_reg[c];
            flag_next[c]    = flag_reg[c];
            hit = (32'(in_item_reg.channel) == c);
            load_v = '0;
            // countdown on tick, flag at zero, reload in repeat mode with a nonzero reload, else go idle
            if (is_tick && running_reg[c]) begin
                if (count_reg[c] == '0) begin
                    flag_next[c] = 1'b1;
                    load_v = (mode_reg[c] == MODE_REPEAT) ? reload_reg[c] : '0;
                    if (load_v == '0) begin
                        running_next[c] = 1'b0;
                        count_next[c]   = IDLE_COUNT;
                    end else begin
                        running_next[c] = 1'b1;
                        count_next[c]   = load_v - 1'b1;
                    end
                end else begin
                    count_next[c] = count_reg[c] - 1'b1;
                end
            end
            // register write
            if (in_item_reg.action == ACT_WRITE && hit) begin
                case (in_item_reg.reg_select)
                    REG_INTERVAL: begin
                        reload_next[c] = wr_v;
                        if (in_item_reg.write_data[FORCE_LOAD_BIT] || !running_reg[c]) begin
                            if (wr_v == '0) begin
                                running_next[c] = 1'b0;
                                count_next[c]   = IDLE_COUNT;
                            end else begin
                                running_next[c] = 1'b1;
                                count_next[c]   = wr_v - 1'b1;
                            end
                        end
                    end
                    REG_CONTROL: begin
                        int_en_next[c] = in_item_reg.write_data[0];
                        mode_next[c]   = in_item_reg.write_data[2:1];
                    end
                    REG_STATUS: begin
                        if (in_item_reg.write_data[0]) begin
                            flag_next[c] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // register read
            if (in_item_reg.action == ACT_READ && hit) begin
                case (in_item_reg.reg_select)
                    REG_INTERVAL: out_item_next.read_data = 32'(reload_reg[c]);
                    REG_CONTROL:  out_item_next.read_data = {29'd0, mode_reg[c], int_en_reg[c]};
                    REG_TIMER:    out_item_next.read_data = 32'(count_reg[c]);
                    default:      out_item_next.read_data = {30'd0, running_reg[c], flag_reg[c]};
                endcase
            end
        end
        // lowest pending enabled channel wins
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (flag_next[c] && int_en_next[c]) begin
                out_item_next.irq         = 1'b1;
                out_item_next.irq_channel = 2'(c);
            end
        end
    end

    // control and channel state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= '0;
            int_en_reg    <= '0;
            flag_reg      <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                reload_reg[c] <= '0;
                count_reg[c]  <= IDLE_COUNT;
                mode_reg[c]   <= MODE_REPEAT;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                running_reg   <= running_next;
                int_en_reg    <= int_en_next;
                flag_reg      <= flag_next;
                for (int c = 0; c < CHANNELS; c++) begin
                    reload_reg[c] <= reload_next[c];
                    count_reg[c]  <= count_next[c];
                    mode_reg[c]   <= mode_next[c];
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

`ifndef NO_ASSERTIONS
    // input stage only blocks when both stages are full and the result stalls
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input blocked without a stalled result");

    // no irq channel reported without an interrupt
    a_irq_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.irq) |-> (m_item.irq_channel == 2'd0))
        else $error("irq channel set while irq is low");

    // an idle channel 0 holds the idle count
    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg[0] |-> (count_reg[0] == IDLE_COUNT))
        else $error("idle channel with a live count");

    // a tick moves a running nonzero count of channel 0 down by one
    a_tick_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.action == ACT_TICK && running_reg[0] && count_reg[0] != '0)
        |=> (count_reg[0] == COUNT_W'($past(count_reg[0]) - 1'b1)))
        else $error("tick did not decrement the count");
`endif

endmodule
